/* rtl/adaptive_range_bit_decoder_core_assert.svh */
// assertion helpers for the range decoder, sampled on clk, off while rst_n is low
`ifndef ADAPTIVE_RANGE_BIT_DECODER_CORE_ASSERT_SVH
`define ADAPTIVE_RANGE_BIT_DECODER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ARBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arbd assertion failed");

// consequent must hold in the cycle after the antecedent
`define ARBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arbd assertion failed");

`endif

/* rtl/arbd_pkg.sv */
package arbd_pkg;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam int NUM_FAMILIES = 8;
  localparam int NUM_ENTRIES  = 432;
  localparam int ENTRY_AW     = 9;
  localparam int PROB_BITS    = 6;
  localparam int HIST_W       = 6;
  localparam int ZEROS_W      = 7;
  localparam int RECENT_W     = 64;

  localparam logic [31:0]         RANGE_INIT  = 32'hffff_ffff;
  localparam logic [31:0]         RENORM_MASK = 32'hffff_0000;
  localparam logic [ZEROS_W-1:0]  ZEROS_INIT  = 7'd48;
  localparam logic [RECENT_W-1:0] RECENT_INIT = 64'h0000_0000_5555_5555;

  typedef struct packed {
    logic [ZEROS_W-1:0]  zeros;
    logic [RECENT_W-1:0] recent;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // first entry of each context family
  function automatic logic [ENTRY_AW-1:0] fam_base(input logic [2:0] fam);
    logic [ENTRY_AW-1:0] base;
    case (fam)
      3'd0:    base = 9'd0;
      3'd1:    base = 9'd16;
      3'd2:    base = 9'd48;
      3'd3:    base = 9'd112;
      3'd4:    base = 9'd176;
      3'd5:    base = 9'd240;
      3'd6:    base = 9'd304;
      3'd7:    base = 9'd368;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

  // family size minus one
  function automatic logic [HIST_W-1:0] fam_mask(input logic [2:0] fam);
    logic [HIST_W-1:0] mask;
    case (fam)
      3'd0:    mask = 6'h0f;
      3'd1:    mask = 6'h1f;
      default: mask = 6'h3f;
    endcase
    return mask;
  endfunction

endpackage

/* rtl/arbd_in_if.sv */
interface arbd_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [2:0]  context_family;
  logic [31:0] initial_code;
  logic [15:0] next_word;
  logic        word_valid;

  modport source (
    output valid, command, context_family, initial_code, next_word, word_valid,
    input  ready
  );

  modport sink (
    input  valid, command, context_family, initial_code, next_word, word_valid,
    output ready
  );
endinterface

/* rtl/arbd_out_if.sv */
interface arbd_out_if;
  logic valid;
  logic ready;
  logic decoded_bit;
  logic word_taken;

  modport source (
    output valid, decoded_bit, word_taken,
    input  ready
  );

  modport sink (
    input  valid, decoded_bit, word_taken,
    output ready
  );
endinterface

/* rtl/arbd_ram.sv */
module arbd_ram #(
  parameter int WIDTH = 71,
  parameter int DEPTH = 432
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/adaptive_range_bit_decoder_core.sv */
// Adaptive binary range decoder. Each entry's bit history and zero count sit in a
// single-port-read RAM whose address comes from the family history that the previous bit
// updates, so a request is taken and its entry read; the bit is decided, written back and
// placed in the output register once that register is free or being read out, and no other
// request is taken meanwhile. A start request (and reset) runs a clearing pass over all 432
// entries, one per cycle, during which no request is taken; its result is delivered at once.
// A result waiting at the output does not stop the next request from being taken.
`include "adaptive_range_bit_decoder_core_assert.svh"

module adaptive_range_bit_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  arbd_in_if.sink     in_ch,
  arbd_out_if.source  out_ch
);

  // request held while its entry is read
  logic                          s1_valid_r;
  logic                          s1_cmd_r;
  logic [2:0]                    s1_fam_r;
  logic [31:0]                   s1_init_r;
  logic [15:0]                   s1_word_r;
  logic                          s1_wv_r;
  logic [arbd_pkg::ENTRY_AW-1:0] s1_idx_r;
  logic [arbd_pkg::HIST_W-1:0]   s1_hist_r;

  logic [31:0] range_r, range_nxt;
  logic [31:0] code_r, code_nxt;
  logic [arbd_pkg::HIST_W-1:0] hist_r [arbd_pkg::NUM_FAMILIES];

  logic                          clearing_r;
  logic [arbd_pkg::ENTRY_AW-1:0] clr_cnt_r;

  logic out_valid_r;
  logic out_bit_r;
  logic out_taken_r;

  logic in_fire;
  logic s1_done;
  logic [arbd_pkg::HIST_W-1:0]   in_hist;
  logic [arbd_pkg::ENTRY_AW-1:0] in_idx;

  logic                          ram_we;
  logic [arbd_pkg::ENTRY_AW-1:0] ram_waddr;
  logic [arbd_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [arbd_pkg::ENTRY_W-1:0]  ram_rdata;

  arbd_pkg::entry_t rd_entry;
  arbd_pkg::entry_t upd_entry;
  arbd_pkg::entry_t init_entry;

  logic [5:0]  chance;
  logic        renorm;
  logic [31:0] range_n;
  logic [31:0] code_n;
  logic [31:0] boundary;
  logic        dec_bit;
  logic        taken;
  logic [arbd_pkg::HIST_W-1:0] hist_upd;

  assign in_ch.ready = !s1_valid_r && !clearing_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_done     = s1_valid_r && (!out_valid_r || out_ch.ready);

  assign in_hist = hist_r[in_ch.context_family] & arbd_pkg::fam_mask(in_ch.context_family);
  assign in_idx  = arbd_pkg::fam_base(in_ch.context_family) + {3'd0, in_hist};

  // decode datapath, on the entry read back from the RAM
  assign rd_entry = arbd_pkg::entry_t'(ram_rdata);

  always_comb begin
    if (rd_entry.zeros == '0) begin
      chance = 6'd1;
    end else if (rd_entry.zeros[6]) begin
      chance = 6'd63;
    end else begin
      chance = rd_entry.zeros[5:0];
    end
  end

  assign renorm   = (range_r & arbd_pkg::RENORM_MASK) == 32'd0;
  assign taken    = renorm && s1_wv_r;
  assign range_n  = renorm ? {range_r[15:0], 16'd0} : range_r;
  assign code_n   = renorm ? {code_r[15:0], (s1_wv_r ? s1_word_r : 16'd0)} : code_r;
  assign boundary = {6'd0, range_n[31:arbd_pkg::PROB_BITS]} * {26'd0, chance};
  assign dec_bit  = !(code_n < boundary);

  assign upd_entry.zeros  = rd_entry.zeros + {6'd0, rd_entry.recent[63]} - {6'd0, dec_bit};
  assign upd_entry.recent = {rd_entry.recent[62:0], dec_bit};
  assign hist_upd = ({s1_hist_r[4:0], 1'b0} & arbd_pkg::fam_mask(s1_fam_r))
                    | {5'd0, dec_bit};

  assign init_entry.zeros  = arbd_pkg::ZEROS_INIT;
  assign init_entry.recent = arbd_pkg::RECENT_INIT;

  always_comb begin
    range_nxt = range_r;
    code_nxt  = code_r;
    if (s1_done) begin
      if (s1_cmd_r == arbd_pkg::CMD_START) begin
        range_nxt = arbd_pkg::RANGE_INIT;
        code_nxt  = s1_init_r;
      end else if (dec_bit) begin
        range_nxt = range_n - boundary;
        code_nxt  = code_n - boundary;
      end else begin
        range_nxt = boundary;
        code_nxt  = code_n;
      end
    end
  end

  // entry RAM: clearing pass or write-back of the decoded request
  always_comb begin
    ram_re = in_fire && (in_ch.command == arbd_pkg::CMD_DECODE);
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = init_entry;
    end else begin
      ram_we    = s1_done && (s1_cmd_r == arbd_pkg::CMD_DECODE);
      ram_waddr = s1_idx_r;
      ram_wdata = upd_entry;
    end
  end

  arbd_ram #(
    .WIDTH(arbd_pkg::ENTRY_W),
    .DEPTH(arbd_pkg::NUM_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.command;
      s1_fam_r  <= in_ch.context_family;
      s1_init_r <= in_ch.initial_code;
      s1_word_r <= in_ch.next_word;
      s1_wv_r   <= in_ch.word_valid;
      s1_idx_r  <= in_idx;
      s1_hist_r <= in_hist;
    end
    if (s1_done) begin
      out_bit_r   <= (s1_cmd_r == arbd_pkg::CMD_DECODE) && dec_bit;
      out_taken_r <= (s1_cmd_r == arbd_pkg::CMD_DECODE) && taken;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      range_r     <= arbd_pkg::RANGE_INIT;
      code_r      <= 32'd0;
      for (int i = 0; i < arbd_pkg::NUM_FAMILIES; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      range_r <= range_nxt;
      code_r  <= code_nxt;

      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 9'd1;
        if (clr_cnt_r == 9'(arbd_pkg::NUM_ENTRIES - 1)) begin
          clearing_r <= 1'b0;
        end
      end

      if (s1_done) begin
        if (s1_cmd_r == arbd_pkg::CMD_START) begin
          clearing_r <= 1'b1;
          clr_cnt_r  <= '0;
          for (int i = 0; i < arbd_pkg::NUM_FAMILIES; i++) begin
            hist_r[i] <= '0;
          end
        end else begin
          hist_r[s1_fam_r] <= hist_upd;
        end
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.decoded_bit = out_bit_r;
  assign out_ch.word_taken  = out_taken_r;

  // the range stays nonzero: after renormalization the split leaves at least range/64 each side
  `ARBD_ASSERT_NOW(a_range_nonzero, 1'b1, range_r != 32'd0)
  // reads and write-backs never share a cycle, so no same-entry hazard
  `ARBD_ASSERT_NOW(a_no_rw_overlap, ram_re, !ram_we)
  // clearing counter stays inside the RAM
  `ARBD_ASSERT_NOW(a_clr_in_range, clearing_r, clr_cnt_r < 9'(arbd_pkg::NUM_ENTRIES))
  // a finished start request launches the clearing pass
  `ARBD_ASSERT_NEXT(a_start_clears, s1_done && (s1_cmd_r == arbd_pkg::CMD_START), clearing_r)
  // every finished request lands in the output register
  `ARBD_ASSERT_NEXT(a_done_to_out, s1_done, out_valid_r && !s1_valid_r)

endmodule

/* verif/adaptive_range_bit_decoder_core_tb.sv */
`timescale 1ns / 1ps

module adaptive_range_bit_decoder_core_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;
  localparam int ITEM_TARGET    = 850;
  localparam int DRAIN_CYCLES   = 20;
  localparam int GAP_PERCENT    = 7;

  typedef struct packed {
    logic decoded_bit;
    logic word_taken;
  } bit_result_t;

  logic clk;
  logic rst_n;

  arbd_in_if  in_ch ();
  arbd_out_if out_ch ();

  adaptive_range_bit_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // decoder state as the predictor sees it
  logic [31:0]                   dec_range;
  logic [31:0]                   dec_code;
  logic [arbd_pkg::HIST_W-1:0]   fam_history [arbd_pkg::NUM_FAMILIES];
  logic [arbd_pkg::ZEROS_W-1:0]  entry_zeros [arbd_pkg::NUM_ENTRIES];
  logic [arbd_pkg::RECENT_W-1:0] entry_recent [arbd_pkg::NUM_ENTRIES];

  bit_result_t pending_bits_q[$];
  int          error_count;
  int          items_sent;
  int          idle_cycles;
  int          holds_requested;
  logic        gaps_on;

  function automatic logic [arbd_pkg::ENTRY_AW-1:0] first_entry(input logic [2:0] fam);
    if (fam == 3'd0) return 9'd0;
    if (fam == 3'd1) return 9'd16;
    return 9'(48 + (int'(fam) - 2) * 64);
  endfunction

  function automatic logic [arbd_pkg::HIST_W-1:0] history_mask(input logic [2:0] fam);
    if (fam == 3'd0) return 6'd15;
    if (fam == 3'd1) return 6'd31;
    return 6'd63;
  endfunction

  function automatic void clear_models();
    for (int i = 0; i < arbd_pkg::NUM_FAMILIES; i++) fam_history[i] = '0;
    for (int i = 0; i < arbd_pkg::NUM_ENTRIES; i++) begin
      entry_zeros[i]  = arbd_pkg::ZEROS_INIT;
      entry_recent[i] = arbd_pkg::RECENT_INIT;
    end
  endfunction

  function automatic bit_result_t next_bit_result(input logic cmd, input logic [2:0] fam,
                                                  input logic [31:0] init,
                                                  input logic [15:0] word, input logic wv);
    bit_result_t                   r;
    logic [arbd_pkg::HIST_W-1:0]   hmask;
    logic [arbd_pkg::HIST_W-1:0]   hist;
    logic [arbd_pkg::ENTRY_AW-1:0] idx;
    logic [arbd_pkg::ZEROS_W-1:0]  zeros;
    logic [31:0]                   chance;
    logic [31:0]                   split;
    logic                          outgoing;
    r = '0;
    if (cmd == arbd_pkg::CMD_START) begin
      dec_range = arbd_pkg::RANGE_INIT;
      dec_code  = init;
      clear_models();
      return r;
    end
    hmask = history_mask(fam);
    hist  = fam_history[fam] & hmask;
    idx   = first_entry(fam) + {3'd0, hist};
    zeros = entry_zeros[idx];
    if (zeros == '0) chance = 32'd1;
    else if (zeros >= 7'd64) chance = 32'd63;
    else chance = 32'(zeros);
    if ((dec_range & arbd_pkg::RENORM_MASK) == '0) begin
      dec_range = dec_range << 16;
      dec_code  = dec_code << 16;
      if (wv) begin
        dec_code[15:0] = word;
        r.word_taken   = 1'b1;
      end
    end
    split = (dec_range >> arbd_pkg::PROB_BITS) * chance;
    if (dec_code < split) begin
      dec_range     = split;
      r.decoded_bit = 1'b0;
    end else begin
      dec_range     = dec_range - split;
      dec_code      = dec_code - split;
      r.decoded_bit = 1'b1;
    end
    outgoing          = entry_recent[idx][arbd_pkg::RECENT_W-1];
    entry_zeros[idx]  = zeros + {6'd0, outgoing} - {6'd0, r.decoded_bit};
    entry_recent[idx] = {entry_recent[idx][arbd_pkg::RECENT_W-2:0], r.decoded_bit};
    fam_history[fam]  = ((hist << 1) & hmask) | {5'd0, r.decoded_bit};
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // watches both channels: requests feed the predictor, results are checked in order
  always @(posedge clk) begin : result_check
    bit_result_t got;
    bit_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_bits_q.push_back(next_bit_result(in_ch.command, in_ch.context_family,
                                                 in_ch.initial_code, in_ch.next_word,
                                                 in_ch.word_valid));
      if (out_ch.valid && out_ch.ready) begin
        got.decoded_bit = out_ch.decoded_bit;
        got.word_taken  = out_ch.word_taken;
        if (pending_bits_q.size() == 0) begin
          report_mismatch("result arrived with none expected");
        end else begin
          want = pending_bits_q.pop_front();
          if (got.decoded_bit !== want.decoded_bit)
            report_mismatch($sformatf("decoded_bit got %b want %b",
                                      got.decoded_bit, want.decoded_bit));
          if (got.word_taken !== want.word_taken)
            report_mismatch($sformatf("word_taken got %b want %b",
                                      got.word_taken, want.word_taken));
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("adaptive_range_bit_decoder_core_tb NOT OK");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on demand
  initial begin : ready_driver
    int holds_served;
    out_ch.ready = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        out_ch.ready = 1'b0;
        for (int held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
      end else begin
        out_ch.ready = !(gaps_on && ($urandom_range(0, 99) < GAP_PERCENT));
      end
    end
  end

  // valid stays high from one request to the next unless a gap is taken
  task automatic send_request(input logic cmd, input logic [2:0] fam, input logic [31:0] init,
                              input logic [15:0] word, input logic wv);
    @(negedge clk);
    while (gaps_on && ($urandom_range(0, 99) < GAP_PERCENT)) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.command        = cmd;
    in_ch.context_family = fam;
    in_ch.initial_code   = init;
    in_ch.next_word      = word;
    in_ch.word_valid     = wv;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic start_block(input logic [31:0] init);
    send_request(arbd_pkg::CMD_START, 3'($urandom_range(0, 7)), init, 16'($urandom),
                 1'($urandom));
  endtask

  task automatic decode_one(input logic [2:0] fam, input logic [15:0] word, input logic wv);
    send_request(arbd_pkg::CMD_DECODE, fam, 32'($urandom), word, wv);
  endtask

  task automatic test_decode_before_start();
    decode_one(3'd0, 16'hffff, 1'b1);
    decode_one(3'd7, 16'h0000, 1'b0);
    decode_one(3'd2, 16'h0000, 1'b1);
  endtask

  task automatic test_start_extremes();
    start_block(32'h0000_0000);
    for (int f = 0; f < arbd_pkg::NUM_FAMILIES; f++)
      decode_one(3'(f), (f % 2 == 0) ? 16'h0000 : 16'hffff, 1'(f / 2));
    start_block(32'hffff_0000);
    start_block(32'hffff_ffff);
    // code at or above the range: every bit is a one and the range shrinks fast
    for (int n = 0; n < 12; n++) decode_one(3'd3, 16'hffff, 1'(n % 2));
  endtask

  task automatic test_probability_clamp();
    // code stuck at zero drives one entry to all zeros
    start_block(32'h0000_0000);
    repeat (70) decode_one(3'd0, 16'h0000, 1'($urandom));
    // code at or above the range drives an entry to all ones
    start_block(32'hffff_ffff);
    repeat (70) decode_one(3'd0, 16'($urandom), 1'($urandom));
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    start_block($urandom);
    repeat (100) decode_one(3'($urandom_range(0, 7)), 16'($urandom), 1'b1);
    gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    start_block($urandom);
    // hold off only once decodes are flowing, so the output and the read stage both fill
    repeat (5) decode_one(3'($urandom_range(0, 7)), 16'($urandom),
                          ($urandom_range(0, 99) < 85));
    holds_requested++;
    repeat (40) decode_one(3'($urandom_range(0, 7)), 16'($urandom),
                           ($urandom_range(0, 99) < 85));
  endtask

  task automatic test_random_blocks();
    int run_len;
    logic [31:0] init;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 5) begin
        // stray request, possibly a restart in the middle of a block
        send_request(1'($urandom), 3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                     1'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       init = 32'h0000_0000;
          1:       init = 32'hffff_ffff;
          default: init = $urandom;
        endcase
        start_block(init);
        run_len = $urandom_range(10, 60);
        repeat (run_len)
          decode_one(3'($urandom_range(0, 7)), 16'($urandom), ($urandom_range(0, 99) < 85));
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.command        = arbd_pkg::CMD_START;
    in_ch.context_family = '0;
    in_ch.initial_code   = '0;
    in_ch.next_word      = '0;
    in_ch.word_valid     = 1'b0;
    gaps_on              = 1'b1;
    error_count          = 0;
    items_sent           = 0;
    idle_cycles          = 0;
    holds_requested      = 0;
    dec_range            = arbd_pkg::RANGE_INIT;
    dec_code             = '0;
    clear_models();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_decode_before_start();
    test_start_extremes();
    test_probability_clamp();
    test_back_to_back();
    test_output_backpressure();
    test_random_blocks();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_bits_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("adaptive_range_bit_decoder_core_tb OK");
    end else begin
      $display("adaptive_range_bit_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/arbd_pkg.sv
rtl/arbd_in_if.sv
rtl/arbd_out_if.sv
rtl/arbd_ram.sv
rtl/adaptive_range_bit_decoder_core.sv
verif/adaptive_range_bit_decoder_core_tb.sv
